// File: src/owner_slot_allocator_core_defines.svh
// assertion macros shared by the owner slot allocator rtl
// users must have clk_i and rst_ni in scope
`ifndef OWNER_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define OWNER_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// checked only outside reset
`define OSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define OSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/osa_pkg.sv
// package of the owner slot allocator: sizes, opcodes, payload and control structs
// no dependencies
`default_nettype none

package osa_pkg;

  localparam int unsigned SLOT_COUNT = 16;
  localparam int unsigned SLOT_BYTES = 256;

  localparam int unsigned OWNER_W = 22;
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned OP_W    = 2;

  localparam int unsigned IDX_W  = $clog2(SLOT_COUNT);
  localparam int unsigned HINT_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned OFF_W  = $clog2(SLOT_BYTES + 1) + IDX_W;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [OWNER_W-1:0] owner_id;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [ADDR_W-1:0]  slot_address;
    logic [INDEX_W-1:0] slot_index;
  } rsp_t;

  // owner table access from the controller
  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [OWNER_W-1:0] wr_data;
    logic               clr;
  } ram_req_t;

  // finished transaction, before the address is formed
  typedef struct packed {
    logic             done;
    logic             ok;
    logic             grant;
    logic [IDX_W-1:0] pick;
  } res_t;

endpackage

`default_nettype wire

// File: src/osa_owner_ram.sv
// owner table: synchronous memory with registered read data and per-entry valid bits
// depends on osa_pkg
`default_nettype none

module osa_owner_ram (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire osa_pkg::ram_req_t ram_i,
  output logic [osa_pkg::OWNER_W-1:0] rd_data_o
);

  logic [osa_pkg::OWNER_W-1:0] mem_q [osa_pkg::SLOT_COUNT];
  logic [osa_pkg::SLOT_COUNT-1:0] vld_q;
  logic [osa_pkg::OWNER_W-1:0] rd_data_q;
  logic                        rd_hit_q;

  // an entry that is not valid reads as a free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (ram_i.clr) begin
        vld_q <= '0;
      end else if (ram_i.wr_en) begin
        vld_q[ram_i.wr_addr] <= 1'b1;
      end
      if (ram_i.rd_en) begin
        rd_hit_q <= vld_q[ram_i.rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_i.wr_en) begin
      mem_q[ram_i.wr_addr] <= ram_i.wr_data;
    end
    if (ram_i.rd_en) begin
      rd_data_q <= mem_q[ram_i.rd_addr];
    end
  end

  assign rd_data_o = rd_hit_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// File: src/osa_ctrl.sv
// allocator sequencer: owner table scan, read-modify-write, free hint and result register
// depends on osa_pkg and owner_slot_allocator_core_defines.svh
`default_nettype none

`include "owner_slot_allocator_core_defines.svh"

module osa_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire osa_pkg::req_t               req_i,
  output logic                             busy_o,
  output osa_pkg::ram_req_t                ram_o,
  input  wire logic [osa_pkg::OWNER_W-1:0] rd_data_i,
  output osa_pkg::res_t                    res_o
);

  localparam int unsigned IdxW  = osa_pkg::IDX_W;
  localparam int unsigned HintW = osa_pkg::HINT_W;

  osa_pkg::state_e state_q, state_d;
  osa_pkg::op_e    op_q;
  logic [osa_pkg::OWNER_W-1:0] owner_q;
  logic [IdxW:0]   issue_q;
  logic            chk_vld_q;
  logic [IdxW-1:0] chk_idx_q;
  logic            found_q;
  logic [IdxW-1:0] pick_q;
  logic [HintW-1:0] hint_q;
  osa_pkg::res_t   res_q;

  logic                        accept;
  logic                        hint_valid;
  logic                        issue_more;
  logic [osa_pkg::OWNER_W-1:0] target;
  logic                        match;
  logic                        last_chk;

  assign accept     = start_i && (state_q == osa_pkg::ST_IDLE);
  assign hint_valid = hint_q < HintW'(osa_pkg::SLOT_COUNT);
  assign issue_more = issue_q < (IdxW + 1)'(osa_pkg::SLOT_COUNT);
  // allocate looks for a free slot, release for the owner
  assign target     = (op_q == osa_pkg::OP_ALLOC) ? '0 : owner_q;
  assign match      = chk_vld_q && (rd_data_i == target);
  assign last_chk   = chk_vld_q && (chk_idx_q == IdxW'(osa_pkg::SLOT_COUNT - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      osa_pkg::ST_IDLE: begin
        if (start_i) begin
          case (osa_pkg::op_e'(req_i.opcode))
            osa_pkg::OP_ALLOC:   state_d = hint_valid ? osa_pkg::ST_FINISH : osa_pkg::ST_SCAN;
            osa_pkg::OP_RELEASE: state_d = osa_pkg::ST_SCAN;
            default:             state_d = osa_pkg::ST_FINISH;
          endcase
        end
      end
      osa_pkg::ST_SCAN: begin
        if (match || last_chk) begin
          state_d = osa_pkg::ST_FINISH;
        end
      end
      osa_pkg::ST_FINISH: state_d = osa_pkg::ST_IDLE;
      default:            state_d = osa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_o         = '0;
    ram_o.rd_addr = issue_q[IdxW-1:0];
    ram_o.wr_addr = pick_q;
    ram_o.wr_data = (op_q == osa_pkg::OP_ALLOC) ? owner_q : '0;
    case (state_q)
      osa_pkg::ST_SCAN: begin
        ram_o.rd_en = issue_more;
      end
      osa_pkg::ST_FINISH: begin
        ram_o.wr_en = found_q &&
                      ((op_q == osa_pkg::OP_ALLOC) || (op_q == osa_pkg::OP_RELEASE));
        ram_o.clr   = (op_q == osa_pkg::OP_CLEAR);
      end
      default: begin
        ram_o.rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= osa_pkg::ST_IDLE;
      hint_q     <= '0;
      chk_vld_q  <= 1'b0;
      found_q    <= 1'b0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      res_q.done <= (state_q == osa_pkg::ST_FINISH);
      if (accept) begin
        chk_vld_q <= 1'b0;
        found_q   <= (osa_pkg::op_e'(req_i.opcode) == osa_pkg::OP_ALLOC) && hint_valid;
      end else if (state_q == osa_pkg::ST_SCAN) begin
        chk_vld_q <= issue_more && !(match || last_chk);
        if (match) begin
          found_q <= 1'b1;
        end
      end else if (state_q == osa_pkg::ST_FINISH) begin
        res_q.ok    <= found_q || (op_q == osa_pkg::OP_CLEAR);
        res_q.grant <= found_q && (op_q == osa_pkg::OP_ALLOC);
        res_q.pick  <= found_q ? pick_q : '0;
        if (found_q && (op_q == osa_pkg::OP_ALLOC)) begin
          hint_q <= HintW'(osa_pkg::SLOT_COUNT);
        end else if (found_q && (op_q == osa_pkg::OP_RELEASE) &&
                     (HintW'(pick_q) < hint_q)) begin
          hint_q <= HintW'(pick_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= osa_pkg::op_e'(req_i.opcode);
      owner_q <= req_i.owner_id;
      issue_q <= '0;
      pick_q  <= hint_q[IdxW-1:0];
    end else if (state_q == osa_pkg::ST_SCAN) begin
      if (issue_more) begin
        issue_q <= issue_q + (IdxW + 1)'(1);
      end
      chk_idx_q <= issue_q[IdxW-1:0];
      if (match) begin
        pick_q <= chk_idx_q;
      end
    end
  end

  assign busy_o = (state_q != osa_pkg::ST_IDLE);
  assign res_o  = res_q;

  `OSA_ASSERT(a_accept_busy, accept |=> busy_o, "accepted transaction did not raise busy")
  `OSA_ASSERT(a_done_after_finish, res_q.done |-> $past(state_q == osa_pkg::ST_FINISH),
              "result strobe without a finishing transaction")
  `OSA_ASSERT(a_grant_kills_hint,
              (state_q == osa_pkg::ST_FINISH && op_q == osa_pkg::OP_ALLOC && found_q) |=>
              (hint_q == HintW'(osa_pkg::SLOT_COUNT)),
              "free hint still valid after a grant")
  `OSA_ASSERT_ALWAYS(a_hint_range, !rst_ni || (hint_q <= HintW'(osa_pkg::SLOT_COUNT)),
                     "free hint beyond slot count")

endmodule

`default_nettype wire

// File: src/owner_slot_allocator_core.sv
// owner slot allocator top level: page base register, slot address, sequencer and owner table
// depends on osa_pkg, osa_ctrl and osa_owner_ram
`default_nettype none

// Usage
// - command channel: a transaction is taken at a clock edge with start high and busy low.
//   req_i.opcode selects allocate, release or clear; req_i.owner_id names the owner.
// - result channel: done_o is high for one cycle with rsp_o; there is no back-pressure,
//   the receiver must take it in that cycle.
// - configuration: cfg_we_i writes cfg_wdata_i into page_start; write only while idle.
// Sequencing (slot count 16 here)
// - allocate with a valid free hint, clear, unused opcode: no scan, straight to the finishing state.
// - allocate without hint, release: the owner table is read one entry per cycle through
//   its single read port into its read register, then a match is written back in the finishing state;
//   the scan stops at the first matching index, or after the last entry when nothing matches.
// - busy drops in the cycle done_o rises, so a new transaction can be taken while the
//   previous result is on the ports.
// Reset
// - asynchronous, active low: every slot free, free hint names slot 0, page_start 0.
//   No clearing pass: per-entry valid bits clear at once.
module owner_slot_allocator_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire osa_pkg::req_t              req_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [osa_pkg::ADDR_W-1:0] cfg_wdata_i,
  output logic                            done_o,
  output osa_pkg::rsp_t                   rsp_o
);

  localparam int unsigned OffW = osa_pkg::OFF_W;

  logic [osa_pkg::ADDR_W-1:0]  page_start_q;
  osa_pkg::ram_req_t           ram_req;
  logic [osa_pkg::OWNER_W-1:0] rd_data;
  osa_pkg::res_t               res;
  logic [OffW-1:0]             offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_start_q <= '0;
    end else if (cfg_we_i) begin
      page_start_q <= cfg_wdata_i;
    end
  end

  osa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_i     (req_i),
    .busy_o    (busy),
    .ram_o     (ram_req),
    .rd_data_i (rd_data),
    .res_o     (res)
  );

  osa_owner_ram u_owner_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ram_i     (ram_req),
    .rd_data_o (rd_data)
  );

  // small constant multiply, address wraps at 64 bits
  assign offset = OffW'(osa_pkg::SLOT_BYTES) * OffW'(res.pick);

  assign done_o             = res.done;
  assign rsp_o.ok           = res.ok;
  assign rsp_o.slot_address = res.grant ?
                              (page_start_q + osa_pkg::ADDR_W'(offset)) : '1;
  assign rsp_o.slot_index   = osa_pkg::INDEX_W'(res.pick);

endmodule

`default_nettype wire
